// ===== hdl/sbca_pkg.sv =====
// shared types and constants for the soft bit combining accumulator
`default_nettype none

package sbca_pkg;

	localparam int KEY_BITS      = 288;
	localparam int BITS_PER_PART = 72;

	// two accumulators share one memory row, one valid bit per row
	localparam int ENTRIES_PER_ROW = 2;
	localparam int ROWS            = KEY_BITS / ENTRIES_PER_ROW;
	localparam int ROW_W           = $clog2(ROWS);

	localparam int ACC_W    = 16;
	localparam int ROW_DW   = ACC_W * ENTRIES_PER_ROW;
	localparam int POS_W    = 9;
	localparam int CMP_W    = 14;
	localparam int WEIGHT_W = 5;
	localparam int SHIFT_W  = 3;
	localparam int METRIC_W = 8;
	localparam int MAG_W    = METRIC_W + WEIGHT_W;
	localparam int PROD_W   = MAG_W + 1;

	localparam logic [WEIGHT_W-1:0] WEIGHT_NO_ERR_RST  = WEIGHT_W'(16);
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE_ERR_RST = WEIGHT_W'(4);
	localparam logic [WEIGHT_W-1:0] WEIGHT_TWO_ERR_RST = WEIGHT_W'(1);
	localparam logic [SHIFT_W-1:0]  LEAK_SHIFT_RST     = SHIFT_W'(3);

	typedef enum logic [1:0] {
		REG_WEIGHT_NO_ERR  = 2'd0,
		REG_WEIGHT_ONE_ERR = 2'd1,
		REG_WEIGHT_TWO_ERR = 2'd2,
		REG_LEAK_SHIFT     = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ERRS_NONE = 4'd0,
		ERRS_ONE  = 4'd1,
		ERRS_TWO  = 4'd2
	} errs_code_t;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [ROW_DW-1:0]       row_data_t;
	typedef logic [ROW_W-1:0]        row_idx_t;

	typedef struct packed {
		logic [1:0]          part;
		logic [6:0]          bit_in_part;
		logic                hard_bit;
		logic [METRIC_W-1:0] soft_metric;
		logic [3:0]          error_count;
		logic                carrier_lock;
	} in_t;

	typedef struct packed {
		logic [POS_W-1:0]        bit_position;
		logic                    hard_decision;
		logic signed [ACC_W-1:0] accumulated;
		logic                    cleared;
	} out_t;

	// row write or whole-store clear, committed on a pipeline advance
	typedef struct packed {
		logic      en;
		logic      clr;
		row_idx_t  row;
		row_data_t data;
	} store_wr_t;

endpackage

`default_nettype wire

// ===== hdl/soft_bit_combining_accumulator.sv =====
// Soft-decision combining accumulator over a 288-bit key, one received bit per transaction.
// Each accepted bit gives one result; the bit moves from s1 through s2 and s3 into the
// output register, where out_valid rises. A new bit is taken every cycle while the output
// is drained. The pipeline stalls as a whole only when the output register holds a result
// that is not taken. The accumulators live in one memory of 144 rows of two entries, read
// in s1 and written back in s3; read-after-write between neighboring bits is covered by
// forwarding, so repeated positions need no gaps. A bit with carrier_lock low clears the
// whole store at once through per-row valid bits: there is no clearing pass after reset or
// after a clear. Configuration writes are always ready and take effect at once; write them
// only while idle.
`default_nettype none

module soft_bit_combining_accumulator
	import sbca_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire in_t                 in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_t                     out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire reg_idx_t            cfg_index,
	input  wire logic [WEIGHT_W-1:0] cfg_data
);

	logic [WEIGHT_W-1:0] weight_no_err_q, weight_one_err_q, weight_two_err_q;
	logic [SHIFT_W-1:0]  leak_shift_q;

	logic adv, s1_en;
	logic v_s1, v_s2, v_s3;
	in_t  in_s1;

	// stage 1 combinational
	logic [CMP_W-1:0]    pos_full;
	logic                in_range;
	logic [WEIGHT_W-1:0] weight;
	logic [MAG_W-1:0]    mag;
	logic signed [PROD_W-1:0] prod_c;
	row_idx_t            rd_row;

	// stage 2 registers
	logic [POS_W-1:0]         pos_s2;
	logic                     lock_s2, upd_s2, half_s2;
	row_idx_t                 row_s2;
	logic signed [PROD_W-1:0] prod_s2;
	row_data_t                rd_data;
	logic                     rd_valid;

	// stage 2 combinational
	row_data_t                fwd_row;
	acc_t                     old_acc;
	logic signed [ACC_W:0]    sum_full;
	acc_t                     sum_sat;

	// stage 3 registers
	logic [POS_W-1:0] pos_s3;
	logic             lock_s3, upd_s3, half_s3;
	row_idx_t         row_s3;
	row_data_t        old_row_s3;
	acc_t             sum_s3;

	// stage 3 combinational
	acc_t      leak;
	acc_t      new_acc;
	row_data_t new_row;
	store_wr_t wr_cmd;
	store_wr_t wr_q;
	out_t      result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_no_err_q  <= WEIGHT_NO_ERR_RST;
			weight_one_err_q <= WEIGHT_ONE_ERR_RST;
			weight_two_err_q <= WEIGHT_TWO_ERR_RST;
			leak_shift_q     <= LEAK_SHIFT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WEIGHT_NO_ERR:  weight_no_err_q  <= cfg_data;
				REG_WEIGHT_ONE_ERR: weight_one_err_q <= cfg_data;
				REG_WEIGHT_TWO_ERR: weight_two_err_q <= cfg_data;
				REG_LEAK_SHIFT:     leak_shift_q     <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves together; s1 may still fill a bubble while stalled
	assign adv      = !out_valid || out_ready;
	assign s1_en    = adv || !v_s1;
	assign in_ready = s1_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				v_s2      <= v_s1;
				v_s3      <= v_s2;
				out_valid <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			in_s1 <= in_data;
		end
	end

	// stage 1: position, range check, weight and signed product
	always_comb begin
		pos_full = CMP_W'(in_s1.part) * CMP_W'(BITS_PER_PART) + CMP_W'(in_s1.bit_in_part);
		in_range = (CMP_W'(in_s1.bit_in_part) < CMP_W'(BITS_PER_PART)) &&
			(pos_full < CMP_W'(KEY_BITS));
		unique case (in_s1.error_count)
			ERRS_NONE: weight = weight_no_err_q;
			ERRS_ONE:  weight = weight_one_err_q;
			ERRS_TWO:  weight = weight_two_err_q;
			default:   weight = '0;
		endcase
		mag    = MAG_W'(in_s1.soft_metric) * MAG_W'(weight);
		prod_c = in_s1.hard_bit ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
		// keep the address inside the array for positions that update nothing
		rd_row = in_range ? ROW_W'(pos_full >> 1) : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s2  <= pos_full[POS_W-1:0];
			lock_s2 <= in_s1.carrier_lock;
			upd_s2  <= in_s1.carrier_lock && in_range;
			half_s2 <= pos_full[0];
			row_s2  <= rd_row;
			prod_s2 <= prod_c;
		end
	end

	sbca_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.rd_row   (rd_row),
		.wr       (wr_cmd),
		.rd_data  (rd_data),
		.rd_valid (rd_valid)
	);

	// stage 2: newest row value, then add and saturate
	always_comb begin
		priority if (v_s3 && !lock_s3) begin
			fwd_row = '0;
		end else if (v_s3 && upd_s3 && row_s3 == row_s2) begin
			fwd_row = new_row;
		end else if (wr_q.clr) begin
			fwd_row = '0;
		end else if (wr_q.en && wr_q.row == row_s2) begin
			fwd_row = wr_q.data;
		end else if (!rd_valid) begin
			fwd_row = '0;
		end else begin
			fwd_row = rd_data;
		end
		old_acc  = half_s2 ? acc_t'(fwd_row[ROW_DW-1:ACC_W]) : acc_t'(fwd_row[ACC_W-1:0]);
		sum_full = {old_acc[ACC_W-1], old_acc} +
			{{(ACC_W+1-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		if (sum_full[ACC_W] != sum_full[ACC_W-1]) begin
			sum_sat = sum_full[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			sum_sat = sum_full[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s3     <= pos_s2;
			lock_s3    <= lock_s2;
			upd_s3     <= upd_s2;
			half_s3    <= half_s2;
			row_s3     <= row_s2;
			old_row_s3 <= fwd_row;
			sum_s3     <= sum_sat;
		end
	end

	// stage 3: leak, row write-back and result
	always_comb begin
		leak    = sum_s3 >>> leak_shift_q;
		new_acc = sum_s3 - leak;
		new_row = half_s3 ? {new_acc, old_row_s3[ACC_W-1:0]} :
			{old_row_s3[ROW_DW-1:ACC_W], new_acc};

		wr_cmd.en   = v_s3 && upd_s3;
		wr_cmd.clr  = v_s3 && !lock_s3;
		wr_cmd.row  = row_s3;
		wr_cmd.data = new_row;

		result = '0;
		if (!lock_s3) begin
			result.cleared = 1'b1;
		end else begin
			result.bit_position = pos_s3;
			if (upd_s3) begin
				result.accumulated   = new_acc;
				result.hard_decision = (new_acc > 0);
			end
		end
	end

	// write committed at the same edge as the read of the bit now in s2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
		end else if (adv) begin
			wr_q <= wr_cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= result;
		end
	end

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.cleared |->
			out_data.accumulated == '0 && out_data.bit_position == '0 &&
			!out_data.hard_decision)
		else $error("cleared result carries nonzero fields");

	a_decision_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hard_decision == (out_data.accumulated > 0))
		else $error("hard decision disagrees with accumulator sign");

	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s3 |=> out_valid && out_data == $past(result))
		else $error("stage 3 transaction not presented at output");

endmodule

`default_nettype wire

// ===== hdl/sbca_store.sv =====
// accumulator row memory with per-row valid bits for clearing all rows at once
`default_nettype none

module sbca_store
	import sbca_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      adv,
	input  wire row_idx_t  rd_row,
	input  wire store_wr_t wr,
	output row_data_t      rd_data,
	output logic           rd_valid
);

	row_data_t        mem [ROWS];
	logic [ROWS-1:0]  row_valid_q;

	// read returns the contents before a same-edge write
	always_ff @(posedge clk) begin
		if (adv && wr.en) begin
			mem[wr.row] <= wr.data;
		end
		if (adv) begin
			rd_data <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid    <= 1'b0;
		end else if (adv) begin
			rd_valid <= row_valid_q[rd_row];
			if (wr.clr) begin
				row_valid_q <= '0;
			end else if (wr.en) begin
				row_valid_q[wr.row] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the soft bit combining accumulator
`timescale 1ns / 100ps

module testbench;
	import sbca_pkg::*;

	localparam int ACC_MAX   = (1 << (ACC_W - 1)) - 1;
	localparam int ACC_MIN   = -(1 << (ACC_W - 1));
	localparam int SETTLE    = 8;
	localparam int PRINT_MAX = 50;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	in_t                 bit_item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_t                update_word;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	reg_idx_t            cfg_index = REG_WEIGHT_NO_ERR;
	logic [WEIGHT_W-1:0] cfg_data = '0;

	// mirror of the accumulator store and register file
	int soft_sums [KEY_BITS];
	int wt_clean = int'(WEIGHT_NO_ERR_RST);
	int wt_one   = int'(WEIGHT_ONE_ERR_RST);
	int wt_two   = int'(WEIGHT_TWO_ERR_RST);
	int leak     = int'(LEAK_SHIFT_RST);

	in_t  pending_bits [$];
	out_t expected_updates [$];
	int   mismatches = 0;

	int burst_left = 1;
	int gap_left = 0;
	int stall_pct = 0;
	int stall_cycle = 0;

	int hot_positions [8] = '{0, 1, 71, 72, 143, 144, 286, 287};

	soft_bit_combining_accumulator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (bit_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (update_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_MAX)
			$display("%0t ns mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// expected update for one received bit, advancing the mirrored store
	function automatic out_t combine_bit(in_t it);
		out_t r;
		int   pos;
		int   w;
		int   acc;
		r = '0;
		if (!it.carrier_lock) begin
			foreach (soft_sums[k])
				soft_sums[k] = 0;
			r.cleared = 1'b1;
			return r;
		end
		pos = int'(it.part) * BITS_PER_PART + int'(it.bit_in_part);
		r.bit_position = POS_W'(pos);
		if (int'(it.bit_in_part) >= BITS_PER_PART || pos >= KEY_BITS)
			return r;
		case (it.error_count)
			ERRS_NONE: w = wt_clean;
			ERRS_ONE:  w = wt_one;
			ERRS_TWO:  w = wt_two;
			default:   w = 0;
		endcase
		acc = soft_sums[pos];
		if (it.hard_bit)
			acc = acc + int'(it.soft_metric) * w;
		else
			acc = acc - int'(it.soft_metric) * w;
		if (acc > ACC_MAX)
			acc = ACC_MAX;
		if (acc < ACC_MIN)
			acc = ACC_MIN;
		// arithmetic shift on int rounds toward minus infinity
		acc = acc - (acc >>> leak);
		soft_sums[pos] = acc;
		r.hard_decision = (acc > 0);
		r.accumulated = ACC_W'(acc);
		return r;
	endfunction

	function automatic in_t make_bit(int part, int bit_idx, int hard, int metric, int errs,
			int lock);
		in_t it;
		it.part = 2'(part);
		it.bit_in_part = 7'(bit_idx);
		it.hard_bit = 1'(hard);
		it.soft_metric = METRIC_W'(metric);
		it.error_count = 4'(errs);
		it.carrier_lock = 1'(lock);
		return it;
	endfunction

	function automatic in_t random_bit();
		in_t it;
		int  pos;
		it.hard_bit = 1'($urandom_range(0, 1));
		it.soft_metric = METRIC_W'($urandom_range(0, 255));
		it.error_count = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 2))
			: 4'($urandom_range(3, 15));
		it.carrier_lock = ($urandom_range(0, 149) != 0);
		if ($urandom_range(0, 15) == 0) begin
			it.part = 2'($urandom_range(0, 3));
			it.bit_in_part = 7'($urandom_range(BITS_PER_PART, 127));
		end else if ($urandom_range(0, 1) == 0) begin
			// a few busy positions so that sums build up and saturate
			pos = hot_positions[$urandom_range(0, 7)];
			it.part = 2'(pos / BITS_PER_PART);
			it.bit_in_part = 7'(pos % BITS_PER_PART);
		end else begin
			it.part = 2'($urandom_range(0, 3));
			it.bit_in_part = 7'($urandom_range(0, BITS_PER_PART - 1));
		end
		return it;
	endfunction

	task automatic check_result(out_t got);
		out_t want;
		if (expected_updates.size() == 0) begin
			report_mismatch($sformatf("unexpected result at position %0d", got.bit_position));
			return;
		end
		want = expected_updates.pop_front();
		if (got.bit_position !== want.bit_position)
			report_mismatch($sformatf("bit_position %0d, want %0d",
				got.bit_position, want.bit_position));
		if (got.hard_decision !== want.hard_decision)
			report_mismatch($sformatf("hard_decision %b, want %b at position %0d",
				got.hard_decision, want.hard_decision, want.bit_position));
		if (got.accumulated !== want.accumulated)
			report_mismatch($sformatf("accumulated %0d, want %0d at position %0d",
				got.accumulated, want.accumulated, want.bit_position));
		if (got.cleared !== want.cleared)
			report_mismatch($sformatf("cleared %b, want %b", got.cleared, want.cleared));
	endtask

	// sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_updates.push_back(combine_bit(bit_item));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_bits.size() > 0) begin
					bit_item <= pending_bits.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure, its stall rate redrawn from 0, 25, 60 or 90 percent
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_result(update_word);
			stall_cycle++;
			if (stall_cycle % 256 == 0) begin
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 25;
					2:       stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [WEIGHT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_WEIGHT_NO_ERR:  wt_clean = int'(val);
			REG_WEIGHT_ONE_ERR: wt_one = int'(val);
			REG_WEIGHT_TWO_ERR: wt_two = int'(val);
			REG_LEAK_SHIFT:     leak = int'(val[SHIFT_W-1:0]);
		endcase
	endtask

	task automatic configure(int w0, int w1, int w2, int shift);
		write_reg(REG_WEIGHT_NO_ERR, WEIGHT_W'(w0));
		write_reg(REG_WEIGHT_ONE_ERR, WEIGHT_W'(w1));
		write_reg(REG_WEIGHT_TWO_ERR, WEIGHT_W'(w2));
		write_reg(REG_LEAK_SHIFT, WEIGHT_W'(shift));
		@(negedge clk);
	endtask

	// sender holds until every outstanding update has been checked
	task automatic drain();
		do
			@(negedge clk);
		while (pending_bits.size() != 0 || in_valid || expected_updates.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	int phase_cfg [5][4] = '{
		'{16, 4, 1, 3},
		'{0, 0, 0, 1},
		'{31, 17, 8, 0},
		'{-1, -1, -1, -1},
		'{9, 31, 2, 7}
	};

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default weights: field extremes, every error class, bad positions, lock loss
		pending_bits.push_back(make_bit(0, 0, 1, 255, 0, 1));
		pending_bits.push_back(make_bit(0, 0, 0, 255, 1, 1));
		pending_bits.push_back(make_bit(3, 71, 1, 128, 2, 1));
		pending_bits.push_back(make_bit(3, 71, 0, 1, 3, 1));
		pending_bits.push_back(make_bit(1, 5, 1, 0, 0, 1));
		pending_bits.push_back(make_bit(2, 10, 1, 200, 15, 1));
		pending_bits.push_back(make_bit(0, 72, 1, 255, 0, 1));
		pending_bits.push_back(make_bit(3, 127, 0, 170, 5, 1));
		pending_bits.push_back(make_bit(1, 127, 1, 85, 10, 1));
		pending_bits.push_back(make_bit(3, 127, 1, 255, 15, 0));
		pending_bits.push_back(make_bit(0, 0, 1, 1, 0, 1));
		pending_bits.push_back(make_bit(3, 71, 0, 3, 0, 1));
		drain();

		// large weights, slow leak: drive one sum into both rails
		configure(31, 31, 31, 7);
		repeat (5) pending_bits.push_back(make_bit(1, 28, 1, 255, 0, 1));
		repeat (9) pending_bits.push_back(make_bit(1, 28, 0, 255, 1, 1));
		pending_bits.push_back(make_bit(1, 28, 1, 255, 2, 1));
		drain();

		foreach (phase_cfg[p]) begin
			if (phase_cfg[p][0] < 0)
				configure($urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 7));
			else
				configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
			repeat (200) pending_bits.push_back(random_bit());
			drain();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
